@@ rtl/core/zpm_pkg.sv @@
// ----------------------------------------------------------------------------
// zpm_pkg: shared types and helpers for the zone pixel/physical mapper
// Holds the opcodes, register indexes, divider cell payload, divisor set and a saturation helper.
// ----------------------------------------------------------------------------
package zpm_pkg;

   // Opcodes of the request channel.
   localparam logic OP_PIX_TO_PHYS = 1'b0;
   localparam logic OP_PHYS_TO_PIX = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_PIXEL_LEFT   = 3'd0;
   localparam logic [2:0] REG_PIXEL_TOP    = 3'd1;
   localparam logic [2:0] REG_PIXEL_WIDTH  = 3'd2;
   localparam logic [2:0] REG_PIXEL_HEIGHT = 3'd3;
   localparam logic [2:0] REG_PHYS_LEFT    = 3'd4;
   localparam logic [2:0] REG_PHYS_TOP     = 3'd5;
   localparam logic [2:0] REG_PHYS_WIDTH   = 3'd6;
   localparam logic [2:0] REG_PHYS_HEIGHT  = 3'd7;

   // One quotient bit is resolved in each divider cell.
   localparam int QUOT_BITS = 48;
   localparam int DIV_BITS  = 31;

   // Divisors for both axes and both opcodes.
   typedef struct packed {
      logic [DIV_BITS-1:0] x0;
      logic [DIV_BITS-1:0] x1;
      logic [DIV_BITS-1:0] y0;
      logic [DIV_BITS-1:0] y1;
   } div_set_type;

   // Item state handed from cell to cell.
   typedef struct packed {
      logic                  mode;
      logic                  neg_x;
      logic                  neg_y;
      logic [QUOT_BITS-1:0]  num_x;
      logic [DIV_BITS-1:0]   rem_x;
      logic [QUOT_BITS-1:0]  num_y;
      logic [DIV_BITS-1:0]   rem_y;
      logic                  in_zone;
      logic [31:0]           clamp_x;
      logic [31:0]           clamp_y;
   } cell_data_type;

   // Saturate a wide signed value into the 32-bit signed range.
   function automatic logic [31:0] sat32(input logic signed [50:0] v);
      logic [31:0] r;
      if (v > 51'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -51'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/core/zpm_div_cell.sv @@
// ----------------------------------------------------------------------------
// zpm_div_cell: one restoring division step for both axes
// Resolves one quotient bit per lane and hands the item to the next cell.
// ----------------------------------------------------------------------------
module zpm_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  zpm_pkg::div_set_type   divs,
   input  logic                   in_valid,
   input  zpm_pkg::cell_data_type in_data,
   output logic                   in_ready,
   output logic                   out_valid,
   output zpm_pkg::cell_data_type out_data,
   input  logic                   out_ready
);
   import zpm_pkg::*;

   logic                  valid_ff;
   cell_data_type         data_ff;
   cell_data_type         data_in;
   logic [DIV_BITS-1:0]   div_x;
   logic [DIV_BITS-1:0]   div_y;
   logic [DIV_BITS:0]     trial_x;
   logic [DIV_BITS:0]     trial_y;
   logic                  bit_x;
   logic                  bit_y;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Shift in the next numerator bit and subtract when the divisor fits.
   always_comb begin
      div_x   = in_data.mode ? divs.x1 : divs.x0;
      div_y   = in_data.mode ? divs.y1 : divs.y0;
      trial_x = {in_data.rem_x, in_data.num_x[QUOT_BITS-1]};
      trial_y = {in_data.rem_y, in_data.num_y[QUOT_BITS-1]};
      bit_x   = trial_x >= {1'b0, div_x};
      bit_y   = trial_y >= {1'b0, div_y};
      data_in       = in_data;
      data_in.num_x = {in_data.num_x[QUOT_BITS-2:0], bit_x};
      data_in.num_y = {in_data.num_y[QUOT_BITS-2:0], bit_y};
      data_in.rem_x = bit_x ? DIV_BITS'(trial_x - {1'b0, div_x}) : trial_x[DIV_BITS-1:0];
      data_in.rem_y = bit_y ? DIV_BITS'(trial_y - {1'b0, div_y}) : trial_y[DIV_BITS-1:0];
   end

   // Cell register; a transfer in happens whenever the cell can drain.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ rtl/core/zone_pixel_physical_mapper_unit.sv @@
// ----------------------------------------------------------------------------
// zone_pixel_physical_mapper_unit: pixel/physical point mapper for one zone
// Scales a point between a zone's pixel and physical rectangles, with
// containment and clamping, through a chain of divider cells.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   opcode, pixel_x/y, mm_x/y
//   rsp      out        rsp_valid/rsp_stall   mapped_x/y, inside_res, clamped_x/y
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// One item enters per cycle while req_stall is low; the path is an operand
// stage, a multiply stage, 48 divider cells (one quotient bit each) and a
// result stage. Reset is synchronous and empties every stage. A stall on rsp
// holds items in place while bubbles ahead of them still fill.
// ----------------------------------------------------------------------------
module zone_pixel_physical_mapper_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [15:0] req_pixel_x,
   input  logic [15:0] req_pixel_y,
   input  logic [31:0] req_mm_x,
   input  logic [31:0] req_mm_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_mapped_x,
   output logic [31:0] rsp_mapped_y,
   output logic        rsp_inside_res,
   output logic [31:0] rsp_clamped_x,
   output logic [31:0] rsp_clamped_y,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import zpm_pkg::*;

   // Configuration registers.
   logic [15:0] pix_left_ff, pix_top_ff, pix_w_ff, pix_h_ff;
   logic [31:0] phy_left_ff, phy_top_ff;
   logic [30:0] phy_w_ff, phy_h_ff;
   logic [15:0] pix_w, pix_h;
   logic [30:0] phy_w, phy_h;
   div_set_type divs;

   // Operand stage.
   logic        a_valid_ff, a_ready;
   logic        a_mode_ff, a_neg_x_ff, a_neg_y_ff, a_inside_ff;
   logic [31:0] a_fa_x_ff, a_fa_y_ff, a_clamp_x_ff, a_clamp_y_ff;
   logic [30:0] a_fb_x_ff, a_fb_y_ff;
   logic        a_neg_x_in, a_neg_y_in, a_inside_in;
   logic [31:0] a_fa_x_in, a_fa_y_in, a_clamp_x_in, a_clamp_y_in;
   logic [30:0] a_fb_x_in, a_fb_y_in;
   logic        in_x_ok, in_y_ok;

   // Multiply stage and divider chain.
   logic          b_ready;
   logic          chain_valid [QUOT_BITS+1];
   logic          chain_ready [QUOT_BITS+1];
   cell_data_type chain_data  [QUOT_BITS+1];
   logic          b_valid_ff;
   cell_data_type b_data_ff, b_data_in;
   logic [62:0]   prod_x, prod_y;

   // Result stage.
   logic          out_valid_ff, out_ready;
   logic [31:0]   out_mx_ff, out_my_ff, out_cx_ff, out_cy_ff;
   logic          out_inside_ff;
   logic [31:0]   out_mx_in, out_my_in;
   cell_data_type fin;

   // Split one axis into a magnitude factor, the other factor and the sign.
   function automatic logic [63:0] axis_operands(input logic mode,
                                                 input logic [15:0] p,
                                                 input logic [31:0] m,
                                                 input logic [15:0] pl,
                                                 input logic [15:0] pw,
                                                 input logic [31:0] ml,
                                                 input logic [30:0] mw);
      logic signed [16:0] dp;
      logic signed [17:0] ap;
      logic        [17:0] magp;
      logic signed [32:0] dm;
      logic        [32:0] magm;
      logic        [63:0] r;
      dp   = $signed({p[15], p}) - $signed({pl[15], pl});
      ap   = {dp, 1'b1};
      magp = ap[17] ? 18'(-ap) : ap;
      dm   = $signed({m[31], m}) - $signed({ml[31], ml});
      magm = dm[32] ? 33'(-dm) : dm;
      if (mode == OP_PHYS_TO_PIX) begin
         r = {dm[32], magm[31:0], 15'd0, pw};
      end else begin
         r = {ap[17], 15'd0, magp[16:0], mw};
      end
      return r;
   endfunction

   // Clamp one axis and flag containment; bit 32 is the containment flag.
   function automatic logic [32:0] axis_clamp(input logic mode,
                                              input logic [15:0] p,
                                              input logic [31:0] m,
                                              input logic [15:0] pl,
                                              input logic [15:0] pw,
                                              input logic [31:0] ml,
                                              input logic [30:0] mw);
      logic signed [34:0] v, lo, hi_ex, hi, c;
      logic               ins;
      if (mode == OP_PHYS_TO_PIX) begin
         v     = 35'($signed(m));
         lo    = 35'($signed(ml));
         hi_ex = lo + $signed({4'd0, mw});
         hi    = hi_ex;
      end else begin
         v     = 35'($signed(p));
         lo    = 35'($signed(pl));
         hi_ex = lo + $signed({19'd0, pw});
         hi    = hi_ex - 35'sd1;
      end
      ins = (v >= lo) && (v < hi_ex);
      if (v < lo) begin
         c = lo;
      end else if (v > hi) begin
         c = hi;
      end else begin
         c = v;
      end
      return {ins, sat32(51'(c))};
   endfunction

   // Configuration writes are taken in every cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_left_ff <= '0;
         pix_top_ff  <= '0;
         pix_w_ff    <= 16'd1920;
         pix_h_ff    <= 16'd1080;
         phy_left_ff <= '0;
         phy_top_ff  <= '0;
         phy_w_ff    <= 31'd134912;
         phy_h_ff    <= 31'd75878;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_PIXEL_LEFT:   pix_left_ff <= csr_data[15:0];
            REG_PIXEL_TOP:    pix_top_ff  <= csr_data[15:0];
            REG_PIXEL_WIDTH:  pix_w_ff    <= csr_data[15:0];
            REG_PIXEL_HEIGHT: pix_h_ff    <= csr_data[15:0];
            REG_PHYS_LEFT:    phy_left_ff <= csr_data;
            REG_PHYS_TOP:     phy_top_ff  <= csr_data;
            REG_PHYS_WIDTH:   phy_w_ff    <= csr_data[30:0];
            REG_PHYS_HEIGHT:  phy_h_ff    <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // A zero size is treated as one.
   always_comb begin
      pix_w   = (pix_w_ff == '0) ? 16'd1 : pix_w_ff;
      pix_h   = (pix_h_ff == '0) ? 16'd1 : pix_h_ff;
      phy_w   = (phy_w_ff == '0) ? 31'd1 : phy_w_ff;
      phy_h   = (phy_h_ff == '0) ? 31'd1 : phy_h_ff;
      divs.x0 = {14'd0, pix_w, 1'b0};
      divs.y0 = {14'd0, pix_h, 1'b0};
      divs.x1 = phy_w;
      divs.y1 = phy_h;
   end

   // Operand stage: differences, magnitudes, clamping and containment.
   always_comb begin
      {a_neg_x_in, a_fa_x_in, a_fb_x_in} = axis_operands(req_opcode, req_pixel_x,
         req_mm_x, pix_left_ff, pix_w, phy_left_ff, phy_w);
      {a_neg_y_in, a_fa_y_in, a_fb_y_in} = axis_operands(req_opcode, req_pixel_y,
         req_mm_y, pix_top_ff, pix_h, phy_top_ff, phy_h);
      {in_x_ok, a_clamp_x_in} = axis_clamp(req_opcode, req_pixel_x, req_mm_x,
         pix_left_ff, pix_w, phy_left_ff, phy_w);
      {in_y_ok, a_clamp_y_in} = axis_clamp(req_opcode, req_pixel_y, req_mm_y,
         pix_top_ff, pix_h, phy_top_ff, phy_h);
      a_inside_in = in_x_ok && in_y_ok;
   end

   assign a_ready   = !a_valid_ff || b_ready;
   assign req_stall = !a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && req_valid) begin
         a_mode_ff    <= req_opcode;
         a_neg_x_ff   <= a_neg_x_in;
         a_neg_y_ff   <= a_neg_y_in;
         a_fa_x_ff    <= a_fa_x_in;
         a_fa_y_ff    <= a_fa_y_in;
         a_fb_x_ff    <= a_fb_x_in;
         a_fb_y_ff    <= a_fb_y_in;
         a_clamp_x_ff <= a_clamp_x_in;
         a_clamp_y_ff <= a_clamp_y_in;
         a_inside_ff  <= a_inside_in;
      end
   end

   // Multiply stage: numerator magnitudes enter the divider chain.
   always_comb begin
      prod_x            = a_fa_x_ff * a_fb_x_ff;
      prod_y            = a_fa_y_ff * a_fb_y_ff;
      b_data_in.mode    = a_mode_ff;
      b_data_in.neg_x   = a_neg_x_ff;
      b_data_in.neg_y   = a_neg_y_ff;
      b_data_in.num_x   = prod_x[QUOT_BITS-1:0];
      b_data_in.num_y   = prod_y[QUOT_BITS-1:0];
      b_data_in.rem_x   = '0;
      b_data_in.rem_y   = '0;
      b_data_in.in_zone = a_inside_ff;
      b_data_in.clamp_x = a_clamp_x_ff;
      b_data_in.clamp_y = a_clamp_y_ff;
   end

   assign b_ready = !b_valid_ff || chain_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_data_ff <= b_data_in;
      end
   end

   assign chain_valid[0] = b_valid_ff;
   assign chain_data[0]  = b_data_ff;

   // Divider chain: one cell per quotient bit.
   for (genvar i = 0; i < QUOT_BITS; i++) begin : g_cell
      zpm_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .divs      (divs),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .in_ready  (chain_ready[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1]),
         .out_ready (chain_ready[i+1])
      );
   end

   assign chain_ready[QUOT_BITS] = out_ready;
   assign fin = chain_data[QUOT_BITS];

   // Result stage: sign and rounding fix-up, offset and saturation.
   always_comb begin
      logic [QUOT_BITS:0]  qa_x, qa_y;
      logic signed [50:0]  sq_x, sq_y, base_x, base_y;
      qa_x = {1'b0, fin.num_x};
      qa_y = {1'b0, fin.num_y};
      if (fin.mode == OP_PIX_TO_PHYS && fin.neg_x && fin.rem_x != '0) begin
         qa_x = qa_x + (QUOT_BITS+1)'(1);
      end
      if (fin.mode == OP_PIX_TO_PHYS && fin.neg_y && fin.rem_y != '0) begin
         qa_y = qa_y + (QUOT_BITS+1)'(1);
      end
      sq_x = fin.neg_x ? -$signed({2'b0, qa_x}) : $signed({2'b0, qa_x});
      sq_y = fin.neg_y ? -$signed({2'b0, qa_y}) : $signed({2'b0, qa_y});
      if (fin.mode == OP_PHYS_TO_PIX) begin
         base_x = 51'($signed(pix_left_ff));
         base_y = 51'($signed(pix_top_ff));
      end else begin
         base_x = 51'($signed(phy_left_ff));
         base_y = 51'($signed(phy_top_ff));
      end
      out_mx_in = sat32(base_x + sq_x);
      out_my_in = sat32(base_y + sq_y);
   end

   assign out_ready = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= chain_valid[QUOT_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && chain_valid[QUOT_BITS]) begin
         out_mx_ff     <= out_mx_in;
         out_my_ff     <= out_my_in;
         out_inside_ff <= fin.in_zone;
         out_cx_ff     <= fin.clamp_x;
         out_cy_ff     <= fin.clamp_y;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_mapped_x   = out_mx_ff;
   assign rsp_mapped_y   = out_my_ff;
   assign rsp_inside_res = out_inside_ff;
   assign rsp_clamped_x  = out_cx_ff;
   assign rsp_clamped_y  = out_cy_ff;

endmodule

@@ bench/zpm_mapping_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zpm_mapping_checker: result checker for the zone pixel/physical mapper
// Watches the csr, req and rsp channels, keeps its own copy of the zone
// registers, computes the expected mapping for each request transfer and
// compares every response transfer with the oldest pending expectation.
// ----------------------------------------------------------------------------
module zpm_mapping_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_opcode,
   input  logic [15:0] req_pixel_x,
   input  logic [15:0] req_pixel_y,
   input  logic [31:0] req_mm_x,
   input  logic [31:0] req_mm_y,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_mapped_x,
   input  logic [31:0] rsp_mapped_y,
   input  logic        rsp_inside_res,
   input  logic [31:0] rsp_clamped_x,
   input  logic [31:0] rsp_clamped_y,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          error_count,
   output int          pending_count
);
   import zpm_pkg::*;

   typedef struct {
      logic [31:0] mapped_x;
      logic [31:0] mapped_y;
      logic        in_zone;
      logic [31:0] clamped_x;
      logic [31:0] clamped_y;
   } mapping_type;

   mapping_type expected_mappings[$];

   // Shadow copy of the zone registers.
   longint zone_pix_left, zone_pix_top, zone_pix_w, zone_pix_h;
   longint zone_phy_left, zone_phy_top, zone_phy_w, zone_phy_h;

   function automatic logic [31:0] saturate(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic longint floor_quot(input longint a, input longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Expected mapping of one request transfer under the current registers.
   function automatic mapping_type map_point(input logic op, input logic [15:0] px,
                                             input logic [15:0] py, input logic [31:0] mx,
                                             input logic [31:0] my);
      mapping_type r;
      longint pw, ph, fw, fh, x, y, xr, yb;
      pw = (zone_pix_w == 0) ? 1 : zone_pix_w;
      ph = (zone_pix_h == 0) ? 1 : zone_pix_h;
      fw = (zone_phy_w == 0) ? 1 : zone_phy_w;
      fh = (zone_phy_h == 0) ? 1 : zone_phy_h;
      if (op == OP_PIX_TO_PHYS) begin
         x = longint'($signed(px));
         y = longint'($signed(py));
         xr = zone_pix_left + pw;
         yb = zone_pix_top + ph;
         r.mapped_x = saturate(zone_phy_left
                               + floor_quot((2 * (x - zone_pix_left) + 1) * fw, 2 * pw));
         r.mapped_y = saturate(zone_phy_top
                               + floor_quot((2 * (y - zone_pix_top) + 1) * fh, 2 * ph));
         r.in_zone = x >= zone_pix_left && y >= zone_pix_top && x < xr && y < yb;
         r.clamped_x = saturate(clip(x, zone_pix_left, xr - 1));
         r.clamped_y = saturate(clip(y, zone_pix_top, yb - 1));
      end else begin
         x = longint'($signed(mx));
         y = longint'($signed(my));
         xr = zone_phy_left + fw;
         yb = zone_phy_top + fh;
         r.mapped_x = saturate(zone_pix_left + ((x - zone_phy_left) * pw) / fw);
         r.mapped_y = saturate(zone_pix_top + ((y - zone_phy_top) * ph) / fh);
         r.in_zone = x >= zone_phy_left && y >= zone_phy_top && x < xr && y < yb;
         r.clamped_x = saturate(clip(x, zone_phy_left, xr));
         r.clamped_y = saturate(clip(y, zone_phy_top, yb));
      end
      return r;
   endfunction

   assign pending_count = expected_mappings.size();

   // Register writes, request transfers and response checks.
   always @(posedge clock) begin
      mapping_type want;
      if (reset) begin
         zone_pix_left <= 0;
         zone_pix_top <= 0;
         zone_pix_w <= 1920;
         zone_pix_h <= 1080;
         zone_phy_left <= 0;
         zone_phy_top <= 0;
         zone_phy_w <= 134912;
         zone_phy_h <= 75878;
         expected_mappings.delete();
         error_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PIXEL_LEFT:   zone_pix_left <= longint'($signed(csr_data[15:0]));
               REG_PIXEL_TOP:    zone_pix_top <= longint'($signed(csr_data[15:0]));
               REG_PIXEL_WIDTH:  zone_pix_w <= longint'(csr_data[15:0]);
               REG_PIXEL_HEIGHT: zone_pix_h <= longint'(csr_data[15:0]);
               REG_PHYS_LEFT:    zone_phy_left <= longint'($signed(csr_data));
               REG_PHYS_TOP:     zone_phy_top <= longint'($signed(csr_data));
               REG_PHYS_WIDTH:   zone_phy_w <= longint'(csr_data[30:0]);
               REG_PHYS_HEIGHT:  zone_phy_h <= longint'(csr_data[30:0]);
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_mappings = {expected_mappings,
                                 map_point(req_opcode, req_pixel_x, req_pixel_y,
                                           req_mm_x, req_mm_y)};
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_mappings.size() == 0) begin
               if (error_count < 10) $display("ERROR: response transfer with none pending");
               error_count <= error_count + 1;
            end else begin
               want = expected_mappings.pop_front();
               if (want.mapped_x !== rsp_mapped_x || want.mapped_y !== rsp_mapped_y
                   || want.in_zone !== rsp_inside_res || want.clamped_x !== rsp_clamped_x
                   || want.clamped_y !== rsp_clamped_y) begin
                  if (error_count < 10) begin
                     $display("ERROR: expected mapped %h %h inside %b clamped %h %h",
                              want.mapped_x, want.mapped_y, want.in_zone,
                              want.clamped_x, want.clamped_y);
                     $display("       actual   mapped %h %h inside %b clamped %h %h",
                              rsp_mapped_x, rsp_mapped_y, rsp_inside_res,
                              rsp_clamped_x, rsp_clamped_y);
                  end
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

@@ bench/tb_zone_pixel_physical_mapper_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zone_pixel_physical_mapper_unit: testbench for the zone mapper
// Drives register settings, directed corner points and random points in
// bursts against a randomly stalling receiver, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_zone_pixel_physical_mapper_unit;
   import zpm_pkg::*;

   localparam int LATENCY = 51;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_opcode;
   logic [15:0] req_pixel_x;
   logic [15:0] req_pixel_y;
   logic [31:0] req_mm_x;
   logic [31:0] req_mm_y;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_mapped_x;
   logic [31:0] rsp_mapped_y;
   logic        rsp_inside_res;
   logic [31:0] rsp_clamped_x;
   logic [31:0] rsp_clamped_y;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;
   int          error_count;
   int          pending_count;
   bit          stimulus_done;
   bit          hold_off_done;

   zone_pixel_physical_mapper_unit i_dut (.*);
   zpm_mapping_checker i_checker (.*);

   // Clock with a 20 ns period.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Receiver stall pattern, with one long hold-off early in the random part.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      hold_off_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_off_done && stimulus_done == 1'b0 && pending_count > 20) begin
            rsp_stall <= 1'b1;
            for (hold = 0; hold < 200; hold++) @(negedge clock);
            hold_off_done = 1'b1;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'($urandom_range(0, 1));
         end
      end
   end

   // Write one register through the csr port.
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Offer one request and wait for its transfer.
   task automatic send_point(input logic op, input logic [15:0] px, input logic [15:0] py,
                             input logic [31:0] mx, input logic [31:0] my);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_pixel_x <= px;
      req_pixel_y <= py;
      req_mm_x <= mx;
      req_mm_y <= my;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Let the pipeline drain before a register change.
   task automatic drain;
      int n;
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      for (n = 0; n < LATENCY + 4; n++) @(negedge clock);
   endtask

   task automatic random_zone;
      int k;
      for (k = 0; k < 8; k++) begin
         case ($urandom_range(0, 4))
            0: write_reg(3'(k), 32'd0);
            1: write_reg(3'(k), 32'hFFFF_FFFF);
            2: write_reg(3'(k), $urandom_range(1, 4));
            default: write_reg(3'(k), $urandom);
         endcase
      end
   endtask

   // Random points, with physical coordinates mostly near zero, sent in bursts.
   task automatic random_points(input int count);
      int sent, burst, gap, g;
      logic [31:0] a, b;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 30);
         while (burst > 0 && sent < count) begin
            a = $urandom;
            b = $urandom;
            if ($urandom_range(0, 2) != 0) begin
               a = $urandom_range(0, 40) - 20;
               b = $urandom_range(0, 40) - 20;
            end
            send_point(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), a, b);
            burst--;
            sent++;
         end
         req_valid <= 1'b0;
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         for (g = 0; g < gap; g++) @(negedge clock);
      end
   endtask

   initial begin
      int phase, w;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_PIX_TO_PHYS;
      req_pixel_x = '0;
      req_pixel_y = '0;
      req_mm_x = '0;
      req_mm_y = '0;
      csr_valid = 1'b0;
      csr_index = REG_PIXEL_LEFT;
      csr_data = '0;
      stimulus_done = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed corners under the reset zone.
      send_point(OP_PIX_TO_PHYS, 16'd0, 16'd0, 32'h1234_5678, 32'h8765_4321);
      send_point(OP_PIX_TO_PHYS, 16'd1919, 16'd1079, '0, '0);
      send_point(OP_PIX_TO_PHYS, 16'd1920, 16'd1080, '0, '0);
      send_point(OP_PIX_TO_PHYS, 16'h8000, 16'h7FFF, '0, '0);
      send_point(OP_PIX_TO_PHYS, 16'hFFFF, 16'hFFFF, '0, '0);
      send_point(OP_PHYS_TO_PIX, 16'hAAAA, 16'h5555, 32'd0, 32'd0);
      send_point(OP_PHYS_TO_PIX, '0, '0, 32'd134911, 32'd75877);
      send_point(OP_PHYS_TO_PIX, '0, '0, 32'd134912, 32'd75878);
      send_point(OP_PHYS_TO_PIX, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_point(OP_PHYS_TO_PIX, '0, '0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      drain();

      // Extreme zone: zero and largest sizes, most negative and most positive edges.
      write_reg(REG_PIXEL_LEFT, 32'h0000_8000);
      write_reg(REG_PIXEL_TOP, 32'h0000_7FFF);
      write_reg(REG_PIXEL_WIDTH, 32'd0);
      write_reg(REG_PIXEL_HEIGHT, 32'hFFFF_FFFF);
      write_reg(REG_PHYS_LEFT, 32'h8000_0000);
      write_reg(REG_PHYS_TOP, 32'h7FFF_FFFF);
      write_reg(REG_PHYS_WIDTH, 32'hFFFF_FFFF);
      write_reg(REG_PHYS_HEIGHT, 32'd0);
      send_point(OP_PIX_TO_PHYS, 16'h8000, 16'h7FFF, '0, '0);
      send_point(OP_PIX_TO_PHYS, 16'h7FFF, 16'h8000, '0, '0);
      send_point(OP_PHYS_TO_PIX, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_point(OP_PHYS_TO_PIX, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_point(OP_PHYS_TO_PIX, '0, '0, 32'h0000_0000, 32'hFFFF_FFFF);
      drain();

      // Random phases; after each one a fresh random zone is written.
      for (phase = 0; phase < 6; phase++) begin
         random_points(125);
         drain();
         random_zone();
      end
      stimulus_done = 1'b1;
      req_valid <= 1'b0;

      w = 0;
      while (pending_count != 0 && w < 100000) begin
         @(negedge clock);
         w++;
      end
      repeat (LATENCY + 10) @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/core/zpm_pkg.sv
rtl/core/zpm_div_cell.sv
rtl/core/zone_pixel_physical_mapper_unit.sv
bench/zpm_mapping_checker.sv
bench/tb_zone_pixel_physical_mapper_unit.sv
